// File: hw/rtl/hazard_alert_monitor_assert.svh
// ----------------------------------------------------------------------------
// Hazard alert monitor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HAZARD_ALERT_MONITOR_ASSERT_SVH
`define HAZARD_ALERT_MONITOR_ASSERT_SVH

// Same-cycle implication
`define HZM_ASSERT_HOLD(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HZM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/hzm_pkg.sv
// ----------------------------------------------------------------------------
// Hazard alert monitor package
// Codes, persistence limits, register reset values and shared types.
// ----------------------------------------------------------------------------
package hzm_pkg;

    // Persistence limits of the earthquake counters
    localparam logic [7:0] DANGER_COUNT     = 8'd5;
    localparam logic [7:0] CALM_CLEAR_COUNT = 8'd5;
    localparam logic [7:0] WATCH_COUNT      = 8'd2;
    localparam logic [7:0] COUNT_MAX        = 8'hFF;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_QUAKE_THRESHOLD        = 4'd0,
        REG_FIRE_TEMP_LIMIT        = 4'd1,
        REG_FIRE_LIGHT_LIMIT       = 4'd2,
        REG_FIRE_WATCH_TEMP        = 4'd3,
        REG_FIRE_WATCH_HUMIDITY    = 4'd4,
        REG_DROUGHT_SOIL_LIMIT     = 4'd5,
        REG_DROUGHT_TEMP_LIMIT     = 4'd6,
        REG_DROUGHT_HUMIDITY_LIMIT = 4'd7
    } cfg_reg_e;

    // Alert codes
    typedef enum logic [1:0] {
        KIND_WATCH  = 2'd0,
        KIND_DANGER = 2'd1,
        KIND_CLEAR  = 2'd2
    } alert_kind_e;

    typedef enum logic [1:0] {
        HZ_QUAKE   = 2'd0,
        HZ_FIRE    = 2'd1,
        HZ_DROUGHT = 2'd2
    } hazard_e;

    // Configuration registers
    typedef struct packed {
        logic        [15:0] quake_threshold;
        logic signed [11:0] fire_temp_limit;
        logic        [11:0] fire_light_limit;
        logic signed [11:0] fire_watch_temp;
        logic        [9:0]  fire_watch_humidity;
        logic        [11:0] drought_soil_limit;
        logic signed [11:0] drought_temp_limit;
        logic        [9:0]  drought_humidity_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        quake_threshold:        16'd500,
        fire_temp_limit:        12'sd300,
        fire_light_limit:       12'd100,
        fire_watch_temp:        12'sd300,
        fire_watch_humidity:    10'd300,
        drought_soil_limit:     12'd1000,
        drought_temp_limit:     12'sd350,
        drought_humidity_limit: 10'd300
    };

    // Climate part of a snapshot, carried through to the alerts
    typedef struct packed {
        logic signed [11:0] temp;
        logic        [9:0]  humidity;
        logic        [11:0] water;
        logic        [11:0] light;
    } snap_t;

    // Monitor state
    typedef struct packed {
        logic [7:0] shake_count;
        logic [7:0] calm_count;
        logic       quake_watch;
        logic       quake_danger;
        logic       fire_watch;
        logic       fire_danger;
        logic       drought_watch;
    } mon_state_t;

    // One alert code and the ordered set raised by one snapshot
    typedef struct packed {
        alert_kind_e kind;
        hazard_e     hazard;
    } alert_code_t;

    typedef struct packed {
        alert_code_t [2:0] slot;
        logic        [1:0] count;
    } alert_set_t;

endpackage

// File: hw/rtl/hzm_if.sv
// ----------------------------------------------------------------------------
// Hazard alert monitor channels
// Snapshot input channel and alert output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hzm_snap_if;
    logic               valid;
    logic               ready;
    logic               climate_valid;
    logic signed [11:0] temp_tenths;
    logic        [9:0]  humidity_tenths;
    logic        [11:0] soil_water;
    logic        [11:0] light_level;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (
        output valid, climate_valid, temp_tenths, humidity_tenths, soil_water,
               light_level, accel_x, accel_y, accel_z,
        input  ready
    );
    modport sink (
        input  valid, climate_valid, temp_tenths, humidity_tenths, soil_water,
               light_level, accel_x, accel_y, accel_z,
        output ready
    );
endinterface

interface hzm_alert_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  alert_kind;
    logic        [1:0]  hazard;
    logic signed [11:0] snap_temp;
    logic        [9:0]  snap_humidity;
    logic        [11:0] snap_water;
    logic        [11:0] snap_light;
    logic        [31:0] magnitude_squared;
    logic               last_alert;

    modport source (
        output valid, alert_kind, hazard, snap_temp, snap_humidity, snap_water,
               snap_light, magnitude_squared, last_alert,
        input  ready
    );
    modport sink (
        input  valid, alert_kind, hazard, snap_temp, snap_humidity, snap_water,
               snap_light, magnitude_squared, last_alert,
        output ready
    );
endinterface

// File: hw/rtl/hazard_alert_monitor.sv
// ----------------------------------------------------------------------------
// Hazard alert monitor
// Sensor snapshot in, earthquake/fire/drought alert words out.
// ----------------------------------------------------------------------------
// A snapshot word can be taken every cycle while the alert side does not stall the
// pipeline. It passes an input register, a register holding the three squared
// axes and the squared threshold, and then the rule evaluation, which loads an
// alert register. A snapshot raises zero to three alert words, delivered one per
// cycle while the receiver is ready, from that alert register in the order
// earthquake, fire, drought; a snapshot with several alerts holds the alert
// register until its last word is taken, and later snapshots wait behind it.
// Snapshots with climate_valid low are taken and dropped. The user must write
// registers through cfg_we/cfg_index/cfg_data only while no snapshot is in flight;
// the block does not enforce this. Unknown indexes are ignored.
module hazard_alert_monitor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hzm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hzm_pkg::CFG_DATA_W-1:0]   cfg_data,
    hzm_snap_if.sink                         snapshot,
    hzm_alert_if.source                      alert
);

    hzm_pkg::cfg_t       cfg_reg;
    hzm_pkg::mon_state_t state_reg;
    hzm_pkg::mon_state_t state_next;
    hzm_pkg::alert_set_t eval_alerts;

    // input register
    logic               a_valid_reg;
    hzm_pkg::snap_t     a_snap_reg;
    logic signed [15:0] a_ax_reg;
    logic signed [15:0] a_ay_reg;
    logic signed [15:0] a_az_reg;

    // squares register
    logic               b_valid_reg;
    hzm_pkg::snap_t     b_snap_reg;
    logic [30:0]        b_sqx_reg;
    logic [30:0]        b_sqy_reg;
    logic [30:0]        b_sqz_reg;
    logic [31:0]        b_thr2_reg;

    // alert register
    hzm_pkg::alert_code_t [2:0] c_slot_reg;
    hzm_pkg::alert_code_t [2:0] c_slot_next;
    logic [1:0]                 c_count_reg;
    logic [1:0]                 c_count_next;
    hzm_pkg::snap_t             c_snap_reg;
    logic [31:0]                c_mag2_reg;

    logic               a_free;
    logic               b_free;
    logic               c_ready;
    logic               eval_fire;
    logic               take;
    logic signed [31:0] prod_x;
    logic signed [31:0] prod_y;
    logic signed [31:0] prod_z;
    logic [31:0]        thr2;
    logic [31:0]        mag2;

    // Pipeline flow control
    assign take      = alert.valid && alert.ready;
    assign c_ready   = (c_count_reg == 2'd0) || (c_count_reg == 2'd1 && alert.ready);
    assign eval_fire = b_valid_reg && c_ready;
    assign b_free    = !b_valid_reg || c_ready;
    assign a_free    = !a_valid_reg || b_free;
    assign snapshot.ready = a_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= hzm_pkg::CFG_RESET;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hzm_pkg::REG_QUAKE_THRESHOLD:
                    cfg_reg.quake_threshold <= cfg_data;
                hzm_pkg::REG_FIRE_TEMP_LIMIT:
                    cfg_reg.fire_temp_limit <= $signed(cfg_data[11:0]);
                hzm_pkg::REG_FIRE_LIGHT_LIMIT:
                    cfg_reg.fire_light_limit <= cfg_data[11:0];
                hzm_pkg::REG_FIRE_WATCH_TEMP:
                    cfg_reg.fire_watch_temp <= $signed(cfg_data[11:0]);
                hzm_pkg::REG_FIRE_WATCH_HUMIDITY:
                    cfg_reg.fire_watch_humidity <= cfg_data[9:0];
                hzm_pkg::REG_DROUGHT_SOIL_LIMIT:
                    cfg_reg.drought_soil_limit <= cfg_data[11:0];
                hzm_pkg::REG_DROUGHT_TEMP_LIMIT:
                    cfg_reg.drought_temp_limit <= $signed(cfg_data[11:0]);
                hzm_pkg::REG_DROUGHT_HUMIDITY_LIMIT:
                    cfg_reg.drought_humidity_limit <= cfg_data[9:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Valid bits of the input and squares registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_valid_reg <= snapshot.valid && snapshot.climate_valid;
            if (b_free)
                b_valid_reg <= a_valid_reg;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (a_free)
        begin
            a_snap_reg.temp     <= snapshot.temp_tenths;
            a_snap_reg.humidity <= snapshot.humidity_tenths;
            a_snap_reg.water    <= snapshot.soil_water;
            a_snap_reg.light    <= snapshot.light_level;
            a_ax_reg            <= snapshot.accel_x;
            a_ay_reg            <= snapshot.accel_y;
            a_az_reg            <= snapshot.accel_z;
        end
    end

    // Squares of the axes and of the threshold
    assign prod_x = a_ax_reg * a_ax_reg;
    assign prod_y = a_ay_reg * a_ay_reg;
    assign prod_z = a_az_reg * a_az_reg;
    assign thr2   = cfg_reg.quake_threshold * cfg_reg.quake_threshold;

    always_ff @(posedge clk)
    begin
        if (b_free)
        begin
            b_snap_reg <= a_snap_reg;
            b_sqx_reg  <= prod_x[30:0];
            b_sqy_reg  <= prod_y[30:0];
            b_sqz_reg  <= prod_z[30:0];
            b_thr2_reg <= thr2;
        end
    end

    // Magnitude sum (at most 3 * 2^30, no wrap) and rule evaluation
    assign mag2 = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg} + {1'b0, b_sqz_reg};

    hzm_eval u_eval (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .snap   (b_snap_reg),
        .mag2   (mag2),
        .thr2   (b_thr2_reg),
        .nxt    (state_next),
        .alerts (eval_alerts)
    );

    // Alert register: shift out on take, reload from evaluation
    always_comb
    begin
        c_slot_next  = c_slot_reg;
        c_count_next = c_count_reg;
        if (take)
        begin
            c_slot_next[0] = c_slot_reg[1];
            c_slot_next[1] = c_slot_reg[2];
            c_count_next   = c_count_reg - 2'd1;
        end
        if (eval_fire && eval_alerts.count != 2'd0)
        begin
            c_slot_next  = eval_alerts.slot;
            c_count_next = eval_alerts.count;
        end
    end

    // Monitor state and alert count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            c_count_reg <= 2'd0;
        end
        else
        begin
            if (eval_fire)
                state_reg <= state_next;
            c_count_reg <= c_count_next;
        end
    end

    // Alert payload
    always_ff @(posedge clk)
    begin
        c_slot_reg <= c_slot_next;
        if (eval_fire && eval_alerts.count != 2'd0)
        begin
            c_snap_reg <= b_snap_reg;
            c_mag2_reg <= mag2;
        end
    end

    // Output word
    assign alert.valid             = c_count_reg != 2'd0;
    assign alert.alert_kind        = c_slot_reg[0].kind;
    assign alert.hazard            = c_slot_reg[0].hazard;
    assign alert.snap_temp         = c_snap_reg.temp;
    assign alert.snap_humidity     = c_snap_reg.humidity;
    assign alert.snap_water        = c_snap_reg.water;
    assign alert.snap_light        = c_snap_reg.light;
    assign alert.magnitude_squared = c_mag2_reg;
    assign alert.last_alert        = c_count_reg == 2'd1;

endmodule

// File: hw/rtl/hzm_eval.sv
// ----------------------------------------------------------------------------
// Hazard rule evaluation
// Counter update, earthquake/fire/drought rules and ordered alert set.
// ----------------------------------------------------------------------------
module hzm_eval (
    input  hzm_pkg::cfg_t       cfg,
    input  hzm_pkg::mon_state_t cur,
    input  hzm_pkg::snap_t      snap,
    input  logic [31:0]         mag2,
    input  logic [31:0]         thr2,
    output hzm_pkg::mon_state_t nxt,
    output hzm_pkg::alert_set_t alerts
);

    logic                 shaking;
    logic                 q_emit;
    logic                 f_emit;
    logic                 d_emit;
    hzm_pkg::alert_kind_e q_kind;
    hzm_pkg::alert_kind_e f_kind;
    hzm_pkg::alert_kind_e d_kind;

    assign shaking = mag2 > thr2;

    // State update and per-hazard notifications
    always_comb
    begin
        nxt    = cur;
        q_emit = 1'b0;
        f_emit = 1'b0;
        d_emit = 1'b0;
        q_kind = hzm_pkg::KIND_WATCH;
        f_kind = hzm_pkg::KIND_WATCH;
        d_kind = hzm_pkg::KIND_WATCH;

        // saturating persistence counters
        if (shaking)
        begin
            if (cur.shake_count != hzm_pkg::COUNT_MAX)
                nxt.shake_count = cur.shake_count + 8'd1;
            nxt.calm_count = 8'd0;
        end
        else
        begin
            if (cur.calm_count != hzm_pkg::COUNT_MAX)
                nxt.calm_count = cur.calm_count + 8'd1;
            if (nxt.calm_count > hzm_pkg::CALM_CLEAR_COUNT)
                nxt.shake_count = 8'd0;
        end

        // earthquake: watch flag left alone while in danger
        if (nxt.shake_count > hzm_pkg::DANGER_COUNT)
        begin
            q_emit           = !cur.quake_danger;
            q_kind           = hzm_pkg::KIND_DANGER;
            nxt.quake_danger = 1'b1;
        end
        else if (nxt.shake_count > hzm_pkg::WATCH_COUNT)
        begin
            q_emit          = !cur.quake_watch;
            q_kind          = hzm_pkg::KIND_WATCH;
            nxt.quake_watch = 1'b1;
        end
        else
        begin
            q_emit           = cur.quake_danger;
            q_kind           = hzm_pkg::KIND_CLEAR;
            nxt.quake_danger = 1'b0;
            nxt.quake_watch  = 1'b0;
        end

        // fire
        if (snap.temp > cfg.fire_temp_limit && snap.light > cfg.fire_light_limit)
        begin
            f_emit          = !cur.fire_danger;
            f_kind          = hzm_pkg::KIND_DANGER;
            nxt.fire_danger = 1'b1;
        end
        else if (snap.temp > cfg.fire_watch_temp &&
                 snap.humidity < cfg.fire_watch_humidity)
        begin
            f_emit         = !cur.fire_watch;
            f_kind         = hzm_pkg::KIND_WATCH;
            nxt.fire_watch = 1'b1;
        end
        else
        begin
            f_emit          = cur.fire_danger;
            f_kind          = hzm_pkg::KIND_CLEAR;
            nxt.fire_danger = 1'b0;
            nxt.fire_watch  = 1'b0;
        end

        // drought
        if (snap.water < cfg.drought_soil_limit ||
            snap.temp > cfg.drought_temp_limit ||
            snap.humidity < cfg.drought_humidity_limit)
        begin
            d_emit            = !cur.drought_watch;
            d_kind            = hzm_pkg::KIND_WATCH;
            nxt.drought_watch = 1'b1;
        end
        else
        begin
            d_emit            = cur.drought_watch;
            d_kind            = hzm_pkg::KIND_CLEAR;
            nxt.drought_watch = 1'b0;
        end
    end

    // Pack notifications in hazard order
    always_comb
    begin
        alerts = '0;
        if (q_emit)
        begin
            alerts.slot[alerts.count] = '{kind: q_kind, hazard: hzm_pkg::HZ_QUAKE};
            alerts.count              = alerts.count + 2'd1;
        end
        if (f_emit)
        begin
            alerts.slot[alerts.count] = '{kind: f_kind, hazard: hzm_pkg::HZ_FIRE};
            alerts.count              = alerts.count + 2'd1;
        end
        if (d_emit)
        begin
            alerts.slot[alerts.count] = '{kind: d_kind, hazard: hzm_pkg::HZ_DROUGHT};
            alerts.count              = alerts.count + 2'd1;
        end
    end

endmodule

// File: hw/rtl/hzm_port_checker.sv
// ----------------------------------------------------------------------------
// Hazard alert monitor port checker
// Checks the alert channel over time, bound to the top level.
// ----------------------------------------------------------------------------
`include "hazard_alert_monitor_assert.svh"

module hzm_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         out_kind,
    input logic [1:0]         out_hazard,
    input logic signed [11:0] out_temp,
    input logic [31:0]        out_mag2,
    input logic               out_last
);

    // A stalled word holds
    `HZM_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_hazard) && $stable(out_last), "alert word changed while stalled")

    // A word that is not the last of its snapshot is followed at once
    `HZM_ASSERT_NEXT(a_burst_cont, out_valid && out_ready && !out_last, out_valid, "alert burst broken off")

    // Within a snapshot, hazards come in increasing order
    `HZM_ASSERT_NEXT(a_burst_order, out_valid && out_ready && !out_last, out_hazard > $past(out_hazard), "alert hazards out of order")

    // Within a snapshot, the snapshot fields do not change
    `HZM_ASSERT_NEXT(a_burst_snap, out_valid && out_ready && !out_last, out_mag2 == $past(out_mag2) && out_temp == $past(out_temp), "snapshot fields changed within burst")

endmodule

bind hazard_alert_monitor hzm_port_checker u_port_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (alert.valid),
    .out_ready  (alert.ready),
    .out_kind   (alert.alert_kind),
    .out_hazard (alert.hazard),
    .out_temp   (alert.snap_temp),
    .out_mag2   (alert.magnitude_squared),
    .out_last   (alert.last_alert)
);

// File: dv/hzm_alert_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hazard alert monitor checker
// Watches the configuration port and both channels. Keeps its own copy of
// the limits and the persistence state, predicts the alert words of every
// snapshot taken and compares each delivered alert word with the oldest one
// still owed.
// ----------------------------------------------------------------------------
module hzm_alert_checker
    import hzm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    hzm_snap_if                    snapshot,
    hzm_alert_if                   alert,
    output int                     fail_count,
    output int                     alerts_pending
);

    // One owed alert word
    typedef struct packed {
        alert_kind_e kind;
        hazard_e     hazard;
        snap_t       snap;
        logic [31:0] mag_sq;
        logic        last;
    } alert_word_t;

    cfg_t        limits;
    mon_state_t  mon;
    alert_word_t owed_alerts[$];

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 'h%0h, actual 'h%0h", field, want, got);
            fail_count++;
        end
    endfunction

    // Rules of one snapshot with good climate data; appends the alert words it raises
    task automatic predict_alerts(input snap_t s, input logic signed [15:0] ax,
                                  input logic signed [15:0] ay, input logic signed [15:0] az);
        alert_code_t        codes[$];
        alert_word_t        word;
        longint             sq_sum;
        logic [31:0]        mag_sq;
        logic [31:0]        thr_sq;
        logic signed [11:0] temp;

        sq_sum = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
        mag_sq = 32'(sq_sum);
        thr_sq = limits.quake_threshold * limits.quake_threshold;
        temp   = s.temp;

        // saturating persistence counters
        if (mag_sq > thr_sq)
        begin
            if (mon.shake_count != COUNT_MAX)
                mon.shake_count++;
            mon.calm_count = '0;
        end
        else
        begin
            if (mon.calm_count != COUNT_MAX)
                mon.calm_count++;
            if (mon.calm_count > CALM_CLEAR_COUNT)
                mon.shake_count = '0;
        end

        // earthquake: watch flag left alone while in danger
        if (mon.shake_count > DANGER_COUNT)
        begin
            if (!mon.quake_danger)
            begin
                codes.push_back(alert_code_t'{KIND_DANGER, HZ_QUAKE});
                mon.quake_danger = 1'b1;
            end
        end
        else if (mon.shake_count > WATCH_COUNT)
        begin
            if (!mon.quake_watch)
            begin
                codes.push_back(alert_code_t'{KIND_WATCH, HZ_QUAKE});
                mon.quake_watch = 1'b1;
            end
        end
        else
        begin
            if (mon.quake_danger)
            begin
                codes.push_back(alert_code_t'{KIND_CLEAR, HZ_QUAKE});
                mon.quake_danger = 1'b0;
            end
            mon.quake_watch = 1'b0;
        end

        // fire
        if (temp > $signed(limits.fire_temp_limit) && s.light > limits.fire_light_limit)
        begin
            if (!mon.fire_danger)
            begin
                codes.push_back(alert_code_t'{KIND_DANGER, HZ_FIRE});
                mon.fire_danger = 1'b1;
            end
        end
        else if (temp > $signed(limits.fire_watch_temp) &&
                 s.humidity < limits.fire_watch_humidity)
        begin
            if (!mon.fire_watch)
            begin
                codes.push_back(alert_code_t'{KIND_WATCH, HZ_FIRE});
                mon.fire_watch = 1'b1;
            end
        end
        else
        begin
            if (mon.fire_danger)
            begin
                codes.push_back(alert_code_t'{KIND_CLEAR, HZ_FIRE});
                mon.fire_danger = 1'b0;
            end
            mon.fire_watch = 1'b0;
        end

        // drought
        if (s.water < limits.drought_soil_limit || temp > $signed(limits.drought_temp_limit)
            || s.humidity < limits.drought_humidity_limit)
        begin
            if (!mon.drought_watch)
            begin
                codes.push_back(alert_code_t'{KIND_WATCH, HZ_DROUGHT});
                mon.drought_watch = 1'b1;
            end
        end
        else if (mon.drought_watch)
        begin
            codes.push_back(alert_code_t'{KIND_CLEAR, HZ_DROUGHT});
            mon.drought_watch = 1'b0;
        end

        foreach (codes[i])
        begin
            word.kind   = codes[i].kind;
            word.hazard = codes[i].hazard;
            word.snap   = s;
            word.mag_sq = mag_sq;
            word.last   = (i == codes.size() - 1);
            owed_alerts.push_back(word);
        end
    endtask

    // Everything sampled on the rising edge, before the edge's updates land
    always @(posedge clk or negedge rst_n)
    begin
        alert_word_t want;
        snap_t       s;

        if (!rst_n)
        begin
            limits = CFG_RESET;
            mon    = '0;
            owed_alerts.delete();
            alerts_pending = 0;
            fail_count     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QUAKE_THRESHOLD:        limits.quake_threshold        = cfg_data;
                    REG_FIRE_TEMP_LIMIT:        limits.fire_temp_limit        = cfg_data[11:0];
                    REG_FIRE_LIGHT_LIMIT:       limits.fire_light_limit       = cfg_data[11:0];
                    REG_FIRE_WATCH_TEMP:        limits.fire_watch_temp        = cfg_data[11:0];
                    REG_FIRE_WATCH_HUMIDITY:    limits.fire_watch_humidity    = cfg_data[9:0];
                    REG_DROUGHT_SOIL_LIMIT:     limits.drought_soil_limit     = cfg_data[11:0];
                    REG_DROUGHT_TEMP_LIMIT:     limits.drought_temp_limit     = cfg_data[11:0];
                    REG_DROUGHT_HUMIDITY_LIMIT: limits.drought_humidity_limit = cfg_data[9:0];
                    default: ;
                endcase
            end

            // compare first: a word delivered now can never belong to a snapshot taken now
            if (alert.valid && alert.ready)
            begin
                if (owed_alerts.size() == 0)
                begin
                    $error("alert word with none owed: kind %0d hazard %0d",
                           alert.alert_kind, alert.hazard);
                    fail_count++;
                end
                else
                begin
                    want = owed_alerts.pop_front();
                    check_field("alert_kind", want.kind, alert.alert_kind);
                    check_field("hazard", want.hazard, alert.hazard);
                    check_field("snap_temp", want.snap.temp, alert.snap_temp);
                    check_field("snap_humidity", want.snap.humidity, alert.snap_humidity);
                    check_field("snap_water", want.snap.water, alert.snap_water);
                    check_field("snap_light", want.snap.light, alert.snap_light);
                    check_field("magnitude_squared", want.mag_sq, alert.magnitude_squared);
                    check_field("last_alert", want.last, alert.last_alert);
                end
            end

            // bad climate reading: dropped, no state change
            if (snapshot.valid && snapshot.ready && snapshot.climate_valid)
            begin
                s.temp     = snapshot.temp_tenths;
                s.humidity = snapshot.humidity_tenths;
                s.water    = snapshot.soil_water;
                s.light    = snapshot.light_level;
                predict_alerts(s, snapshot.accel_x, snapshot.accel_y, snapshot.accel_z);
            end

            alerts_pending = owed_alerts.size();
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hazard alert monitor testbench
// Directed snapshots through the earthquake, fire and drought sequences, a
// long shaking run into counter saturation, then random shake/calm episodes
// under several limit settings (reset, minimum, maximum, random) and idle
// patterns on both channels. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
    import hzm_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 10;
    localparam int STALL_LIMIT    = 2000;
    localparam int PHASE_WORDS    = 27;
    localparam int PHASES         = 5;
    localparam int SATURATE_WORDS = 260;
    localparam int NUM_REGS       = 8;

    // One snapshot word as driven onto the channel
    typedef struct {
        logic               climate_valid;
        logic signed [11:0] temp;
        logic        [9:0]  humidity;
        logic        [11:0] water;
        logic        [11:0] light;
        logic signed [15:0] accel [3];
    } snap_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     alerts_pending;
    int                     idle_pct = 0;
    int                     stall_pct = 0;
    int                     quiet_cycles = 0;
    cfg_t                   limits = CFG_RESET;

    hzm_snap_if  snapshot ();
    hzm_alert_if alert ();

    hazard_alert_monitor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .snapshot  (snapshot),
        .alert     (alert)
    );

    hzm_alert_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .snapshot       (snapshot),
        .alert          (alert),
        .fail_count     (fail_count),
        .alerts_pending (alerts_pending)
    );

    always #2 clk = ~clk;

    // Alert receiver: random back-pressure
    always @(posedge clk)
    begin
        alert.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles with no word moving and no register write
    always @(posedge clk)
    begin
        if ((snapshot.valid && snapshot.ready) || (alert.valid && alert.ready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic snap_word_t snapshot_word(int cv, int t, int h, int w, int l,
                                                 int x, int y, int z);
        snap_word_t s;

        s.climate_valid = cv[0];
        s.temp          = 12'(t);
        s.humidity      = 10'(h);
        s.water         = 12'(w);
        s.light         = 12'(l);
        s.accel[0]      = 16'(x);
        s.accel[1]      = 16'(y);
        s.accel[2]      = 16'(z);
        return s;
    endfunction

    // A value within three of a limit, wrapping at the field width
    function automatic int near(int base);
        return base + int'($urandom_range(6)) - 3;
    endfunction

    // Random snapshot, climate mostly near the current limits
    function automatic snap_word_t random_snapshot(bit shaking);
        snap_word_t w;
        int         axis;
        int         span;

        w.climate_valid = ($urandom_range(9) != 0);
        case ($urandom_range(3))
            0:       w.temp = 12'($urandom());
            1:       w.temp = 12'(near($signed(limits.fire_temp_limit)));
            2:       w.temp = 12'(near($signed(limits.fire_watch_temp)));
            default: w.temp = 12'(near($signed(limits.drought_temp_limit)));
        endcase
        case ($urandom_range(2))
            0:       w.humidity = 10'($urandom());
            1:       w.humidity = 10'(near(limits.fire_watch_humidity));
            default: w.humidity = 10'(near(limits.drought_humidity_limit));
        endcase
        w.water = $urandom_range(1) ? 12'($urandom()) : 12'(near(limits.drought_soil_limit));
        w.light = $urandom_range(1) ? 12'($urandom()) : 12'(near(limits.fire_light_limit));

        // acceleration: full range or just over, else at most half or on the threshold
        axis = $urandom_range(2);
        foreach (w.accel[i])
            w.accel[i] = '0;
        if (shaking)
        begin
            if (limits.quake_threshold < 16'd32767 && $urandom_range(3) == 0)
                w.accel[axis] = limits.quake_threshold + 16'd1;
            else
                foreach (w.accel[i])
                    w.accel[i] = 16'($urandom());
        end
        else if (limits.quake_threshold <= 16'd32767 && $urandom_range(3) == 0)
            w.accel[axis] = limits.quake_threshold;
        else
        begin
            span = limits.quake_threshold / 2;
            foreach (w.accel[i])
                w.accel[i] = 16'($urandom_range(span));
        end
        foreach (w.accel[i])
            if ($urandom_range(1))
                w.accel[i] = -w.accel[i];
        return w;
    endfunction

    // Offer one word, with random idle cycles in front; returns once taken
    task automatic send_snapshot(input snap_word_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            snapshot.valid <= 1'b0;
            @(posedge clk);
        end
        snapshot.valid           <= 1'b1;
        snapshot.climate_valid   <= w.climate_valid;
        snapshot.temp_tenths     <= w.temp;
        snapshot.humidity_tenths <= w.humidity;
        snapshot.soil_water      <= w.water;
        snapshot.light_level     <= w.light;
        snapshot.accel_x         <= w.accel[0];
        snapshot.accel_y         <= w.accel[1];
        snapshot.accel_z         <= w.accel[2];
        @(posedge clk);
        while (!snapshot.ready)
            @(posedge clk);
    endtask

    // Stop offering, wait for every owed alert, then let the pipeline empty
    task automatic drain();
        snapshot.valid <= 1'b0;
        @(posedge clk);
        while (alerts_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_we is left high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // All registers with junk in the unused upper bits, then a write to a spare index
    task automatic apply_limits(input cfg_t l);
        logic [CFG_DATA_W-1:0] junk;

        junk = CFG_DATA_W'($urandom());
        write_reg(REG_QUAKE_THRESHOLD, l.quake_threshold);
        write_reg(REG_FIRE_TEMP_LIMIT, {junk[15:12], l.fire_temp_limit});
        write_reg(REG_FIRE_LIGHT_LIMIT, {junk[15:12], l.fire_light_limit});
        write_reg(REG_FIRE_WATCH_TEMP, {junk[15:12], l.fire_watch_temp});
        write_reg(REG_FIRE_WATCH_HUMIDITY, {junk[15:10], l.fire_watch_humidity});
        write_reg(REG_DROUGHT_SOIL_LIMIT, {junk[15:12], l.drought_soil_limit});
        write_reg(REG_DROUGHT_TEMP_LIMIT, {junk[15:12], l.drought_temp_limit});
        write_reg(REG_DROUGHT_HUMIDITY_LIMIT, {junk[15:10], l.drought_humidity_limit});
        write_reg(CFG_INDEX_W'($urandom_range((1 << CFG_INDEX_W) - 1, NUM_REGS)),
                  CFG_DATA_W'($urandom()));
        cfg_we <= 1'b0;
        @(posedge clk);
        limits = l;
    endtask

    // Stimulus
    initial
    begin
        snap_word_t w;
        cfg_t       l;
        int         sent;
        int         shake_run;
        int         calm_run;

        cfg_we                   <= 1'b0;
        cfg_index                <= '0;
        cfg_data                 <= '0;
        snapshot.valid           <= 1'b0;
        snapshot.climate_valid   <= 1'b0;
        snapshot.temp_tenths     <= '0;
        snapshot.humidity_tenths <= '0;
        snapshot.soil_water      <= '0;
        snapshot.light_level     <= '0;
        snapshot.accel_x         <= '0;
        snapshot.accel_y         <= '0;
        snapshot.accel_z         <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset limits: bad climate ignored, threshold edge, watch/danger/clear
        send_snapshot(snapshot_word(0, 2047, 0, 0, 4095, -32768, -32768, -32768));
        send_snapshot(snapshot_word(1, 0, 500, 2000, 50, 0, 0, 0));
        send_snapshot(snapshot_word(1, -2048, 1023, 4095, 0, 500, 0, 0));
        send_snapshot(snapshot_word(1, 2047, 0, 0, 4095, 501, 0, 0));
        send_snapshot(snapshot_word(1, 2047, 0, 0, 4095, -32768, -32768, -32768));
        send_snapshot(snapshot_word(0, 0, 500, 2000, 50, 0, 0, 0));
        send_snapshot(snapshot_word(1, 2047, 0, 0, 4095, 32767, 32767, 32767));
        send_snapshot(snapshot_word(1, 2047, 0, 0, 4095, 0, -501, 0));
        send_snapshot(snapshot_word(1, 2047, 0, 0, 4095, 0, -501, 0));
        // quake danger while fire drops from danger to watch
        send_snapshot(snapshot_word(1, 400, 100, 2000, 50, 0, 0, -32768));
        repeat (5) send_snapshot(snapshot_word(1, 0, 500, 2000, 50, 0, 0, 0));
        // sixth calm clears the quake; fire danger and drought watch in the same word
        send_snapshot(snapshot_word(1, 301, 299, 999, 101, 1, -1, 1));
        send_snapshot(snapshot_word(1, 301, 299, 1000, 100, 0, 0, 0));
        send_snapshot(snapshot_word(1, 350, 300, 1000, 100, 0, 0, 0));
        send_snapshot(snapshot_word(1, 351, 300, 1000, 100, 0, 0, 0));

        // Long shaking run with good climate: shake count must stick at its maximum
        idle_pct  = 16;
        stall_pct = 16;
        for (int k = 0; k < SATURATE_WORDS + 8; k++)
        begin
            w               = random_snapshot(k < SATURATE_WORDS);
            w.climate_valid = 1'b1;
            send_snapshot(w);
        end

        // Random episodes under each limit setting and idle pattern
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0: l = CFG_RESET;
                1: l = '{16'd0, 12'h800, 12'd0, 12'h800, 10'd0, 12'd0, 12'h800, 10'd0};
                2: l = '{16'hFFFF, 12'h7FF, 12'hFFF, 12'h7FF, 10'h3FF, 12'hFFF, 12'h7FF,
                         10'h3FF};
                default:
                begin
                    l.quake_threshold        = 16'($urandom_range(3000));
                    l.fire_temp_limit        = 12'(int'($urandom_range(1650)) - 400);
                    l.fire_light_limit       = 12'($urandom_range(4095));
                    l.fire_watch_temp        = 12'(int'($urandom_range(1650)) - 400);
                    l.fire_watch_humidity    = 10'($urandom_range(1000));
                    l.drought_soil_limit     = 12'($urandom_range(4095));
                    l.drought_temp_limit     = 12'(int'($urandom_range(1650)) - 400);
                    l.drought_humidity_limit = 10'($urandom_range(1000));
                end
            endcase
            apply_limits(l);

            case (phase)
                1:       begin idle_pct = 63; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 63; end
                3:       begin idle_pct = 16; stall_pct = 16; end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase

            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                shake_run = $urandom_range(9);
                calm_run  = $urandom_range(8);
                for (int k = 0; k < shake_run + calm_run && sent < PHASE_WORDS; k++)
                begin
                    send_snapshot(random_snapshot(k < shake_run));
                    sent++;
                end
            end
        end

        drain();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
